// ===== hw/rtl/esd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the escape sequence decoder: parse modes, character codes,
// the per-character result bundle and the hex digit decoder. No dependencies.
package esd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_ZERO   = 3'd2,
    MODE_OCT    = 3'd3,
    MODE_HEX1   = 3'd4,
    MODE_HEX2   = 3'd5
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  // Octal digits taken after the first one when the escape closes by itself.
  localparam logic [1:0] OCT_LAST_CNT = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Results caused by one character: up to two bytes, then an optional end marker.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] nbytes;
    logic       last_end;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Returns {ok, value}; ok is low for a character that is not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/esd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the escape sequence decoder:
// the character input channel and the decoded result channel. No dependencies.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;
  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_end;
  modport source (output valid, out_byte, out_valid, out_end, input ready);
  modport sink   (input valid, out_byte, out_valid, out_end, output ready);
endinterface

// ===== hw/rtl/esd_front.sv =====
`timescale 1ns / 1ps
// Front end of the escape sequence decoder: parse state machine that turns
// each accepted character into one result bundle. Depends on esd_pkg.
module esd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_char,
  input  logic            in_last,
  output logic            push,
  output esd_pkg::bundle_t bnd
);
  import esd_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       is_oct;
  logic       plain;
  logic [7:0] oct_acc;
  logic [1:0] cnt_inc;
  logic [4:0] hx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 8'd0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    bnd      = '0;
    plain    = 1'b0;
    is_oct   = (in_char[7:3] == 5'b00110);
    oct_acc  = {acc_r[4:0], in_char[2:0]};
    cnt_inc  = cnt_r + 2'd1;
    hx       = hex_decode(in_char);

    unique case (mode_r) inside
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        acc_nxt  = 8'd0;
        cnt_nxt  = 2'd0;
        if (in_char == CH_N) begin
          bnd.b0 = BYTE_LF;
          bnd.nbytes = 2'd1;
        end else if (in_char == CH_R) begin
          bnd.b0 = BYTE_CR;
          bnd.nbytes = 2'd1;
        end else if (in_char == CH_T) begin
          bnd.b0 = BYTE_TAB;
          bnd.nbytes = 2'd1;
        end else if (in_char == CH_BSLASH) begin
          bnd.b0 = CH_BSLASH;
          bnd.nbytes = 2'd1;
        end else if (in_char == CH_ZERO) begin
          mode_nxt = MODE_ZERO;
        end else if (is_oct) begin
          mode_nxt = MODE_OCT;
          acc_nxt  = {5'd0, in_char[2:0]};
        end
        // Any other character after a backslash is dropped.
      end
      MODE_ZERO, MODE_OCT: begin
        if (mode_r == MODE_ZERO && in_char == CH_X) begin
          mode_nxt = MODE_HEX1;
          acc_nxt  = 8'd0;
        end else if (is_oct) begin
          if (cnt_inc == OCT_LAST_CNT) begin
            bnd.b0     = oct_acc;
            bnd.nbytes = 2'd1;
            mode_nxt   = MODE_NORMAL;
            acc_nxt    = 8'd0;
            cnt_nxt    = 2'd0;
          end else begin
            mode_nxt = MODE_OCT;
            acc_nxt  = oct_acc;
            cnt_nxt  = cnt_inc;
          end
        end else begin
          // A non-octal character closes the escape and is then ordinary text.
          bnd.b0     = acc_r;
          bnd.nbytes = 2'd1;
          mode_nxt   = MODE_NORMAL;
          acc_nxt    = 8'd0;
          cnt_nxt    = 2'd0;
          plain      = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (hx[4]) begin
          mode_nxt = MODE_HEX2;
          acc_nxt  = {4'd0, hx[3:0]};
        end else begin
          mode_nxt = MODE_NORMAL;
          acc_nxt  = 8'd0;
          cnt_nxt  = 2'd0;
          plain    = 1'b1;
        end
      end
      MODE_HEX2: begin
        mode_nxt = MODE_NORMAL;
        acc_nxt  = 8'd0;
        cnt_nxt  = 2'd0;
        if (hx[4]) begin
          bnd.b0     = {acc_r[3:0], hx[3:0]};
          bnd.nbytes = 2'd1;
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        acc_nxt  = 8'd0;
        cnt_nxt  = 2'd0;
        plain    = 1'b1;
      end
    endcase

    if (plain) begin
      if (in_char == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else if (bnd.nbytes == 2'd0) begin
        bnd.b0     = in_char;
        bnd.nbytes = 2'd1;
      end else begin
        bnd.b1     = in_char;
        bnd.nbytes = 2'd2;
      end
    end

    if (in_last) begin
      // A pending octal value is flushed; the escape can only be pending when
      // this character produced no byte of its own.
      if (mode_nxt == MODE_ZERO || mode_nxt == MODE_OCT) begin
        if (bnd.nbytes == 2'd0) begin
          bnd.b0     = acc_nxt;
          bnd.nbytes = 2'd1;
        end else begin
          bnd.b1     = acc_nxt;
          bnd.nbytes = 2'd2;
        end
      end
      mode_nxt     = MODE_NORMAL;
      acc_nxt      = 8'd0;
      cnt_nxt      = 2'd0;
      bnd.last_end = 1'b1;
    end
  end

  assign push = accept && ((bnd.nbytes != 2'd0) || bnd.last_end);

`ifndef SYNTH
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (mode_r == MODE_NORMAL && acc_r == 8'd0 && cnt_r == 2'd0))
    else $error("state not cleared after the last character");
`endif

endmodule

// ===== hw/rtl/esd_fifo.sv =====
`timescale 1ns / 1ps
// Short register queue of result bundles between the decoder front and back.
// Depends on esd_pkg.
module esd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  esd_pkg::bundle_t wdata,
  input  logic             pop,
  output esd_pkg::bundle_t rdata,
  output esd_pkg::q_stat_t stat
);
  import esd_pkg::*;

  bundle_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

// ===== hw/rtl/esd_back.sv =====
`timescale 1ns / 1ps
// Back end of the escape sequence decoder: walks the head bundle one result
// at a time into the output register. Depends on esd_pkg.
module esd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  esd_pkg::bundle_t head,
  input  esd_pkg::q_stat_t stat,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_vld,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_end
);
  import esd_pkg::*;

  logic       vld_r;
  logic [7:0] byte_r;
  logic       bval_r;
  logic       end_r;
  logic [1:0] idx_r;

  logic       load;
  logic [1:0] total;
  logic       is_byte;

  assign load    = !vld_r || out_ready;
  assign total   = head.nbytes + {1'b0, head.last_end};
  assign is_byte = (idx_r < head.nbytes);
  assign pop     = load && !stat.empty && (idx_r == total - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      vld_r <= !stat.empty;
      if (!stat.empty) begin
        idx_r <= pop ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      byte_r <= is_byte ? ((idx_r == 2'd0) ? head.b0 : head.b1) : 8'd0;
      bval_r <= is_byte;
      end_r  <= !is_byte;
    end
  end

  assign out_vld   = vld_r;
  assign out_byte  = byte_r;
  assign out_valid = bval_r;
  assign out_end   = end_r;

`ifndef SYNTH
  a_idx_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !stat.empty)
    else $error("result index set with no bundle at the head");
`endif

endmodule

// ===== hw/rtl/escape_sequence_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the escape sequence decoder: front parser, bundle queue and
// result serializer. Depends on esd_pkg, esd_ifs, esd_front, esd_fifo, esd_back.
//
//   Channel  Dir  Payload                          Transaction when
//   in_ch    in   in_char[7:0], in_last            in_ch.valid && in_ch.ready
//   out_ch   out  out_byte[7:0], out_valid, out_end out_ch.valid && out_ch.ready
//
// One character is accepted per cycle while the bundle queue has room; the
// front parser updates its state in that same cycle and queues the results.
// The output register delivers one result per cycle while out_ch.ready is
// high, so a character that causes two or three results holds the output
// longer; the four-entry queue absorbs such bursts. A result passes from the
// queue into the output register. Reset is synchronous and active low and
// clears the parser state, the queue pointers and the output valid; out_ch
// stalls back up through the queue into in_ch.ready only when the queue fills.
module escape_sequence_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  esd_in_if.sink     in_ch,
  esd_out_if.source  out_ch
);
  import esd_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  bundle_t bnd;
  bundle_t head;
  q_stat_t stat;

  // The front takes a character whenever the queue can hold its bundle.
  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && !stat.full;

  esd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_char (in_ch.in_char),
    .in_last (in_ch.in_last),
    .push    (push),
    .bnd     (bnd)
  );

  // Characters that cause no result (an opening backslash, a digit inside an
  // escape) push nothing, so the queue only holds work for the back end.
  esd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (bnd),
    .pop   (pop),
    .rdata (head),
    .stat  (stat)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (out_ch.ready),
    .out_vld   (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_valid (out_ch.out_valid),
    .out_end   (out_ch.out_end)
  );

endmodule

// ===== tb/escape_sequence_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for escape_sequence_decoder_top: directed and random
// character strings, a bit-accurate decoder model and a scoreboard on the results.
// Depends on esd_pkg, esd_ifs and the decoder RTL.
module escape_sequence_decoder_top_test;
  import esd_pkg::*;

  // Roughly how many random characters follow the directed strings.
  localparam int RAND_CHARS   = 320;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AFTER   = 100;
  // Quiet cycles after the last result, covering the output register delay.
  localparam int TAIL_CYCLES  = 10;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 10;

  // One source character as the driver offers it.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } src_char_t;

  // One result transaction on the output channel.
  typedef struct packed {
    logic [7:0] dbyte;
    logic       dvalid;
    logic       dend;
  } dec_result_t;

  logic clk;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Characters still to be offered, and decoded results still to arrive.
  src_char_t   pending_chars[$];
  dec_result_t decoded_q[$];

  // Decoder model state.
  mode_t      parse_st;
  logic [7:0] acc;
  logic [1:0] oct_taken;

  // Bookkeeping.
  logic in_taken;
  int   chars_taken;
  int   results_seen;
  int   strings_done;
  int   faults;
  int   directed_n;

  // Sender pacing.
  int burst_left;
  int gap_left;

  // Receiver pacing.
  int  seg_left;
  int  seg_mode;
  int  hold_left;
  bit  hold_done;
  int  hold_stall_cycles;

  // ---------------------------------------------------------------------------
  // Decoder model. It mirrors the parser one character at a time and appends
  // the results that each character completes to decoded_q.
  // ---------------------------------------------------------------------------
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic go_normal();
    parse_st  = MODE_NORMAL;
    acc       = 8'h00;
    oct_taken = 2'd0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    decoded_q.push_back('{dbyte: b, dvalid: 1'b1, dend: 1'b0});
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    logic as_text;
    logic is_oct;
    int   nib;
    is_oct  = (c >= "0" && c <= "7");
    as_text = 1'b0;
    case (parse_st)
      MODE_ESC: begin
        // The character after a backslash never passes through as text; an
        // unknown one is simply dropped.
        go_normal();
        if (c == CH_N) put_byte(BYTE_LF);
        else if (c == CH_R) put_byte(BYTE_CR);
        else if (c == CH_T) put_byte(BYTE_TAB);
        else if (c == CH_BSLASH) put_byte(CH_BSLASH);
        else if (c == CH_ZERO) parse_st = MODE_ZERO;
        else if (is_oct) begin
          parse_st = MODE_OCT;
          acc      = c - CH_ZERO;
        end
      end
      MODE_ZERO, MODE_OCT: begin
        if (parse_st == MODE_ZERO && c == CH_X) begin
          parse_st = MODE_HEX1;
          acc      = 8'h00;
        end else if (is_oct) begin
          acc       = (acc << 3) + (c - CH_ZERO);
          oct_taken = oct_taken + 2'd1;
          if (oct_taken == OCT_LAST_CNT) begin
            put_byte(acc);
            go_normal();
          end else begin
            parse_st = MODE_OCT;
          end
        end else begin
          // A non-octal character closes the escape and is then plain text.
          put_byte(acc);
          go_normal();
          as_text = 1'b1;
        end
      end
      MODE_HEX1: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          acc      = nib[7:0];
          parse_st = MODE_HEX2;
        end else begin
          go_normal();
          as_text = 1'b1;
        end
      end
      MODE_HEX2: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          put_byte((acc << 4) + nib[7:0]);
          go_normal();
        end else begin
          // The first digit is lost and the failing character is plain text.
          go_normal();
          as_text = 1'b1;
        end
      end
      default: begin
        go_normal();
        as_text = 1'b1;
      end
    endcase
    if (as_text) begin
      if (c == CH_BSLASH) parse_st = MODE_ESC;
      else put_byte(c);
    end
    if (last) begin
      if (parse_st == MODE_ZERO || parse_st == MODE_OCT) put_byte(acc);
      go_normal();
      decoded_q.push_back('{dbyte: 8'h00, dvalid: 1'b0, dend: 1'b1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back('{ch: c, last: 1'b0});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic close_string();
    pending_chars[pending_chars.size() - 1].last = 1'b1;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_oct_char();
    return 8'("0" + $urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  // Appends one well-formed or deliberately broken piece of text.
  task automatic add_token();
    int         pick;
    int         ndig;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
      push_char(c);
    end else if (pick < 45) begin
      push_char(CH_BSLASH);
      case ($urandom_range(0, 3))
        0: push_char(CH_N);
        1: push_char(CH_R);
        2: push_char(CH_T);
        default: push_char(CH_BSLASH);
      endcase
    end else if (pick < 60) begin
      queue_text("\\0x");
      push_char(rand_hex_char());
      push_char(rand_hex_char());
    end else if (pick < 75) begin
      // Octal escape of one to four digits; a leading zero takes the
      // zero-prefixed path but stays octal.
      push_char(CH_BSLASH);
      ndig = $urandom_range(1, 4);
      for (int i = 0; i < ndig; i++) push_char(rand_oct_char());
    end else if (pick < 83) begin
      push_char(CH_BSLASH);
      do c = 8'($urandom_range(0, 255));
      while (c == CH_N || c == CH_R || c == CH_T || c == CH_BSLASH ||
             (c >= "0" && c <= "7"));
      push_char(c);
    end else if (pick < 91) begin
      // Broken hex escape, with or without a first digit.
      queue_text("\\0x");
      if ($urandom_range(0, 1) == 1) push_char(rand_hex_char());
      push_char(rand_non_hex());
    end else begin
      push_char(8'($urandom_range(0, 255)));
    end
  endtask

  // A string may also stop in the middle of an escape.
  task automatic add_open_tail();
    case ($urandom_range(0, 4))
      0: push_char(CH_BSLASH);
      1: queue_text("\\0x");
      2: begin
        queue_text("\\0x");
        push_char(rand_hex_char());
      end
      3: queue_text("\\0");
      default: begin
        push_char(CH_BSLASH);
        push_char(rand_oct_char());
        if ($urandom_range(0, 1) == 1) push_char(rand_oct_char());
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers pending characters in bursts with gaps between them. Once
  // valid is up it stays up with the same character until the transaction
  // completes. Everything changes on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_char <= 8'h00;
      in_ch.in_last <= 1'b0;
    end else begin
      if (in_taken) void'(pending_chars.pop_front());
      if (in_ch.valid && !in_taken) begin
        // Still waiting for ready: keep the offer unchanged.
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= pending_chars[0].ch;
        in_ch.in_last <= pending_chars[0].last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows segments of random length, each with its own stall
  // density. Once, after some traffic, it holds ready low for HOLD_CYCLES so
  // the internal queue fills and the input channel backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left         = hold_left - 1;
      hold_stall_cycles = hold_stall_cycles + 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
      hold_done         = 1'b1;
      hold_left         = HOLD_CYCLES - 1;
      hold_stall_cycles = 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (seg_left <= 0) begin
        seg_left = $urandom_range(10, 60);
        seg_mode = $urandom_range(0, 3);
      end
      seg_left = seg_left - 1;
      case (seg_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. At each rising edge the result transaction, if any, is checked
  // against the oldest decoded result first; then an accepted character is
  // run through the model. A result always trails its character through the
  // queue and the output register, so this order never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dec_result_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        faults = faults + 1;
        if (faults <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: byte %02h valid %b end %b",
                   $realtime, out_ch.out_byte, out_ch.out_valid, out_ch.out_end);
      end else begin
        want = decoded_q.pop_front();
        results_seen = results_seen + 1;
        if (want.dend) strings_done = strings_done + 1;
        if (out_ch.out_byte !== want.dbyte || out_ch.out_valid !== want.dvalid ||
            out_ch.out_end !== want.dend) begin
          faults = faults + 1;
          if (faults <= REPORT_LIMIT)
            $display("%0t: result %0d: byte %02h/%02h valid %b/%b end %b/%b (want/got)",
                     $realtime, results_seen, want.dbyte, out_ch.out_byte,
                     want.dvalid, out_ch.out_valid, want.dend, out_ch.out_end);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      decode_char(in_ch.in_char, in_ch.in_last);
      chars_taken = chars_taken + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: fill the character queue, release reset, wait for every
  // character and every result, then report.
  // ---------------------------------------------------------------------------
  initial begin
    int drain;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    in_taken      = 1'b0;
    chars_taken   = 0;
    results_seen  = 0;
    strings_done  = 0;
    faults        = 0;
    burst_left    = 0;
    gap_left      = 0;
    seg_left      = 0;
    seg_mode      = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    hold_stall_cycles = 0;
    go_normal();

    // Directed strings: byte extremes and every simple escape; hex in both
    // cases and a hex escape that fails after its first digit; an octal escape
    // that closes by itself on the fourth digit, one closed by a letter, an
    // unknown escape and a backslash as the last character; finally a lone
    // zero escape flushed by the end of the string.
    push_char(8'h00);
    push_char(8'hFF);
    queue_text("\\n\\r\\t\\\\");
    close_string();
    queue_text("\\0xaF\\0x4G");
    close_string();
    queue_text("\\1234\\7z\\q\\");
    close_string();
    queue_text("\\0");
    close_string();
    directed_n = pending_chars.size();

    // Random strings, mostly well-formed escapes with random content.
    while (pending_chars.size() < directed_n + RAND_CHARS) begin
      repeat ($urandom_range(1, 10)) add_token();
      if ($urandom_range(0, 5) == 0) add_open_tail();
      close_string();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_chars.size() == 0);
    for (drain = 0; drain < DRAIN_LIMIT && decoded_q.size() != 0; drain++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (decoded_q.size() != 0) begin
      faults = faults + decoded_q.size();
      $display("%0d decoded results never arrived", decoded_q.size());
    end

    $display("Ran %0d characters (%0d directed) in %0d strings, %0d results checked.",
             chars_taken, directed_n, strings_done, results_seen);
    $display("Receiver held off for %0d cycles once; %0d mismatches in total.",
             hold_stall_cycles, faults);
    if (faults == 0) begin
      $display("escape_sequence_decoder_top_test: clean");
    end else begin
      $display("escape_sequence_decoder_top_test: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Run did not finish in time.");
    $display("escape_sequence_decoder_top_test: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/esd_pkg.sv
hw/rtl/esd_ifs.sv
hw/rtl/esd_front.sv
hw/rtl/esd_fifo.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder_top.sv
tb/escape_sequence_decoder_top_test.sv
